>>> design/assert_macros.svh
// Assertion helpers for the design files; fis_fmul includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FIS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define FIS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define FIS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define FIS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> design/fis_pkg.sv
package fis_pkg;

	localparam logic [31:0] MAGIC           = 32'h5f3759df;
	localparam logic [31:0] FP_HALF         = 32'h3F000000;
	localparam logic [31:0] FP_THREE_HALVES = 32'h3FC00000;
	localparam logic [31:0] FP_QNAN         = 32'h7FC00000;
	localparam logic [31:0] FP_INF          = 32'h7F800000;
	localparam logic [31:0] SIGN_MASK       = 32'h80000000;

	typedef logic signed [12:0] exp_t;

	typedef struct packed {
		exp_t        e;
		logic [23:0] m;
	} unp_t;

	// operation state before normalise/round; special carries a finished result
	typedef struct packed {
		logic        special;
		logic [31:0] spec_res;
		logic        sign;
		exp_t        e;
		logic [62:0] m;
	} prenorm_t;

	function automatic logic is_nan(logic [31:0] a);
		return a[30:0] > FP_INF[30:0];
	endfunction

	function automatic logic is_inf(logic [31:0] a);
		return a[30:0] == FP_INF[30:0];
	endfunction

	function automatic logic is_zero(logic [31:0] a);
		return a[30:0] == 31'd0;
	endfunction

	// finite nonzero operand: value = m * 2^(e-150), m[23] set
	function automatic unp_t unpack(logic [31:0] a);
		unp_t        u;
		logic [23:0] f;
		logic [4:0]  lz;
		logic        found;
		f     = {1'b0, a[22:0]};
		lz    = '0;
		found = 1'b0;
		for (int i = 23; i >= 0; i--) begin
			if (!found && f[i]) begin
				found = 1'b1;
				lz    = 5'(23 - i);
			end
		end
		if (a[30:23] == 8'd0) begin
			u.m = f << lz;
			u.e = 13'sd1 - exp_t'({8'd0, lz});
		end else begin
			u.m = {1'b1, a[22:0]};
			u.e = exp_t'({5'd0, a[30:23]});
		end
		return u;
	endfunction

	// m has its leading one at bit 62
	function automatic logic [31:0] round_pack(logic sign, exp_t e, logic [62:0] m);
		logic [12:0] sh;
		logic [62:0] mm;
		logic [23:0] mant;
		logic [38:0] rem;
		logic        up;
		logic [7:0]  ebias;
		logic [32:0] u;
		logic [31:0] r;
		mm    = m;
		ebias = 8'd0;
		sh    = '0;
		if (e >= 13'sd255) begin
			r = {sign, FP_INF[30:0]};
		end else begin
			if (e <= 13'sd0) begin
				sh = 13'(13'sd1 - e);
				if (sh > 13'd62) begin
					mm = 63'd1;
				end else begin
					mm = (m >> sh) | {62'd0, |(m & ((63'd1 << sh) - 63'd1))};
				end
			end else begin
				ebias = 8'(e - 13'sd1);
			end
			mant = mm[62:39];
			rem  = mm[38:0];
			up   = (rem > {1'b1, 38'd0}) || ((rem == {1'b1, 38'd0}) && mant[0]);
			u    = {2'b0, ebias, 23'd0} + {9'd0, mant} + {32'd0, up};
			if (u >= {1'b0, FP_INF}) begin
				r = {sign, FP_INF[30:0]};
			end else begin
				r = {sign, u[30:0]};
			end
		end
		return r;
	endfunction

	function automatic prenorm_t mul_front(logic [31:0] a, logic [31:0] b);
		prenorm_t    p;
		unp_t        ua;
		unp_t        ub;
		logic [47:0] prod;
		p.special  = 1'b1;
		p.sign     = a[31] ^ b[31];
		p.e        = '0;
		p.m        = '0;
		p.spec_res = '0;
		if (is_nan(a) || is_nan(b)) begin
			p.spec_res = FP_QNAN;
		end else if (is_inf(a) || is_inf(b)) begin
			p.spec_res = (is_zero(a) || is_zero(b)) ? FP_QNAN : {p.sign, FP_INF[30:0]};
		end else if (is_zero(a) || is_zero(b)) begin
			p.spec_res = {p.sign, 31'd0};
		end else begin
			ua        = unpack(a);
			ub        = unpack(b);
			prod      = 48'(ua.m) * 48'(ub.m);
			p.special = 1'b0;
			p.e       = ua.e + ub.e - 13'sd126;
			p.m       = {prod, 15'd0};
		end
		return p;
	endfunction

	function automatic logic [31:0] mul_back(prenorm_t p);
		logic [62:0] m;
		exp_t        e;
		m = p.m;
		e = p.e;
		if (!m[62]) begin
			m = m << 1;
			e = e - 13'sd1;
		end
		return p.special ? p.spec_res : round_pack(p.sign, e, m);
	endfunction

	function automatic prenorm_t add_front(logic [31:0] a, logic [31:0] b);
		prenorm_t    p;
		unp_t        ua;
		unp_t        ub;
		unp_t        hi;
		unp_t        lo;
		logic        shi;
		logic        slo;
		logic [62:0] xa;
		logic [62:0] xb;
		logic [12:0] d;
		logic [63:0] r;
		p.special  = 1'b1;
		p.sign     = 1'b0;
		p.e        = '0;
		p.m        = '0;
		p.spec_res = '0;
		if (is_nan(a) || is_nan(b)) begin
			p.spec_res = FP_QNAN;
		end else if (is_inf(a) && is_inf(b)) begin
			p.spec_res = (a[31] == b[31]) ? a : FP_QNAN;
		end else if (is_inf(a)) begin
			p.spec_res = a;
		end else if (is_inf(b)) begin
			p.spec_res = b;
		end else if (is_zero(a) && is_zero(b)) begin
			p.spec_res = {a[31] & b[31], 31'd0};
		end else if (is_zero(a)) begin
			p.spec_res = b;
		end else if (is_zero(b)) begin
			p.spec_res = a;
		end else begin
			ua = unpack(a);
			ub = unpack(b);
			if ((ub.e > ua.e) || ((ub.e == ua.e) && (ub.m > ua.m))) begin
				hi = ub; lo = ua; shi = b[31]; slo = a[31];
			end else begin
				hi = ua; lo = ub; shi = a[31]; slo = b[31];
			end
			xa = {hi.m, 39'd0};
			xb = {lo.m, 39'd0};
			d  = 13'(hi.e - lo.e);
			if (d > 13'd62) begin
				xb = 63'd1;
			end else if (d != 13'd0) begin
				xb = (xb >> d) | {62'd0, |(xb & ((63'd1 << d) - 63'd1))};
			end
			p.sign = shi;
			p.e    = hi.e;
			if (shi == slo) begin
				r = {1'b0, xa} + {1'b0, xb};
				if (r[63]) begin
					r   = (r >> 1) | {63'd0, r[0]};
					p.e = hi.e + 13'sd1;
				end
				p.special = 1'b0;
			end else begin
				r = {1'b0, xa} - {1'b0, xb};
				// exact cancellation gives +0
				p.special = (r == 64'd0);
			end
			p.m = r[62:0];
		end
		return p;
	endfunction

	// leading-one search and shift after cancellation
	function automatic prenorm_t add_norm(prenorm_t p);
		prenorm_t   q;
		logic [5:0] lz;
		logic       found;
		q     = p;
		lz    = '0;
		found = 1'b0;
		for (int i = 62; i >= 0; i--) begin
			if (!found && p.m[i]) begin
				found = 1'b1;
				lz    = 6'(62 - i);
			end
		end
		if (!p.special) begin
			q.m = p.m << lz;
			q.e = p.e - exp_t'({7'd0, lz});
		end
		return q;
	endfunction

endpackage

>>> design/operand_if.sv
interface operand_if;
	logic        valid;
	logic        ready;
	logic [31:0] operand_bits;

	modport source(output valid, output operand_bits, input ready);
	modport sink(input valid, input operand_bits, output ready);
endinterface

>>> design/result_if.sv
interface result_if;
	logic        valid;
	logic        ready;
	logic [31:0] recip_root_bits;

	modport source(output valid, output recip_root_bits, input ready);
	modport sink(input valid, input recip_root_bits, output ready);
endinterface

>>> design/fis_fmul.sv
`include "assert_macros.svh"

// Two-stage single-precision multiply: unpack and mantissa product, then round.
module fis_fmul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        vld_in,
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  logic [31:0] aux_in,
	output logic        vld_out,
	output logic [31:0] res,
	output logic [31:0] aux_out
);

	fis_pkg::prenorm_t pre_s1;
	logic              vld_s1;
	logic [31:0]       aux_s1;
	logic              vld_s2;
	logic [31:0]       res_s2;
	logic [31:0]       aux_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pre_s1 <= fis_pkg::mul_front(a, b);
			aux_s1 <= aux_in;
			res_s2 <= fis_pkg::mul_back(pre_s1);
			aux_s2 <= aux_s1;
		end
	end

	assign vld_out = vld_s2;
	assign res     = res_s2;
	assign aux_out = aux_s2;

	`FIS_ASSERT_NEXT(a_nan_kept, clk, arst_n, en && vld_s1 && pre_s1.special && (pre_s1.spec_res == fis_pkg::FP_QNAN), res_s2 == fis_pkg::FP_QNAN, "NaN lost in multiply")
	`FIS_ASSERT_NEXT(a_no_nan_made, clk, arst_n, en && vld_s1 && !pre_s1.special, !fis_pkg::is_nan(res_s2), "finite product gave NaN")
	`FIS_ASSERT_NEXT(a_stall_hold, clk, arst_n, !en, $stable(vld_s2) && $stable(res_s2), "stage moved in stall")

endmodule

>>> design/fis_fadd.sv
// Three-stage single-precision add: align and add, normalise, round.
module fis_fadd (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        vld_in,
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  logic [31:0] aux_in,
	output logic        vld_out,
	output logic [31:0] res,
	output logic [31:0] aux_out
);

	fis_pkg::prenorm_t pre_s1;
	fis_pkg::prenorm_t pre_s2;
	logic              vld_s1;
	logic              vld_s2;
	logic              vld_s3;
	logic [31:0]       aux_s1;
	logic [31:0]       aux_s2;
	logic [31:0]       aux_s3;
	logic [31:0]       res_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pre_s1 <= fis_pkg::add_front(a, b);
			aux_s1 <= aux_in;
			pre_s2 <= fis_pkg::add_norm(pre_s1);
			aux_s2 <= aux_s1;
			res_s3 <= pre_s2.special ? pre_s2.spec_res
				: fis_pkg::round_pack(pre_s2.sign, pre_s2.e, pre_s2.m);
			aux_s3 <= aux_s2;
		end
	end

	assign vld_out = vld_s3;
	assign res     = res_s3;
	assign aux_out = aux_s3;

endmodule

>>> design/fast_inverse_sqrt.sv
// Channel   Dir  Payload                  Handshake
// operand   in   operand_bits[31:0]      valid/ready
// result    out  recip_root_bits[31:0]   valid/ready
//
// One request per cycle sustained while results are taken. Eleven register stages in
// series: four multiplies of two stages and one subtract of three.
// arst_n clears all stage valid bits; the data registers are not reset.
// A stall at result freezes every stage together; operand.ready drops only
// while the output register holds a result that is not taken.

module fast_inverse_sqrt (
	input logic           clk,
	input logic           arst_n,
	operand_if.sink       operand,
	result_if.source      result
);

	logic        en;
	logic [31:0] x;
	logic [31:0] y0;

	logic        vld_m1;
	logic [31:0] xhalf_m1;
	logic [31:0] y_m1;
	logic        vld_m2;
	logic [31:0] p_m2;
	logic [31:0] y_m2;
	logic        vld_m3;
	logic [31:0] t_m3;
	logic [31:0] y_m3;
	logic        vld_a;
	logic [31:0] c_a;
	logic [31:0] y_a;
	logic        vld_o;
	logic [31:0] r_o;

	// whole pipe advances unless the output register is full and blocked
	assign en            = !vld_o || result.ready;
	assign operand.ready = en;

	// integer first guess: magic minus the pattern shifted right arithmetically
	assign x  = operand.operand_bits;
	assign y0 = fis_pkg::MAGIC - {x[31], x[31:1]};

	// xhalf = 0.5 * x, guess rides alongside
	fis_fmul u_m_half (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_in(operand.valid), .a(x), .b(fis_pkg::FP_HALF), .aux_in(y0),
		.vld_out(vld_m1), .res(xhalf_m1), .aux_out(y_m1)
	);

	// xhalf * y
	fis_fmul u_m_xy (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_in(vld_m1), .a(xhalf_m1), .b(y_m1), .aux_in(y_m1),
		.vld_out(vld_m2), .res(p_m2), .aux_out(y_m2)
	);

	// (xhalf * y) * y
	fis_fmul u_m_xyy (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_in(vld_m2), .a(p_m2), .b(y_m2), .aux_in(y_m2),
		.vld_out(vld_m3), .res(t_m3), .aux_out(y_m3)
	);

	// 1.5 - t, as an add with the sign of t flipped
	fis_fadd u_a_sub (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_in(vld_m3), .a(fis_pkg::FP_THREE_HALVES), .b(t_m3 ^ fis_pkg::SIGN_MASK),
		.aux_in(y_m3),
		.vld_out(vld_a), .res(c_a), .aux_out(y_a)
	);

	// y * c; its last stage is the output register
	fis_fmul u_m_out (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_in(vld_a), .a(y_a), .b(c_a), .aux_in(y_a),
		.vld_out(vld_o), .res(r_o), .aux_out()
	);

	assign result.valid           = vld_o;
	assign result.recip_root_bits = r_o;

endmodule

>>> tb/tb_fast_inverse_sqrt.sv
module tb_fast_inverse_sqrt;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PIPE_LATENCY = 11;
	localparam logic [31:0] TWIST = 32'h5f3759df;

	// float helpers kept local so the prediction is independent of the block
	function automatic bit f_nan(logic [31:0] a);
		return a[30:0] > 31'h7F800000;
	endfunction
	function automatic bit f_inf(logic [31:0] a);
		return a[30:0] == 31'h7F800000;
	endfunction
	function automatic bit f_zero(logic [31:0] a);
		return a[30:0] == 31'd0;
	endfunction

	// value = mant * 2^(ex-150), mant[23] set
	function automatic void split(logic [31:0] a, output int ex, output logic [23:0] mant);
		ex = a[30:23];
		mant = {1'b0, a[22:0]};
		if (ex == 0) begin
			ex = 1;
			while (!mant[23]) begin
				mant = mant << 1;
				ex--;
			end
		end else begin
			mant[23] = 1'b1;
		end
	endfunction

	function automatic logic [31:0] pack_round(bit sgn, int ex, logic [63:0] m);
		logic [63:0] mant, rem, u;
		bit up;
		int sh;
		while (!m[62]) begin
			m = m << 1;
			ex--;
		end
		if (ex >= 255) return {sgn, 31'h7F800000};
		if (ex <= 0) begin
			sh = 1 - ex;
			if (sh > 62) m = 64'd1;
			else m = (m >> sh) | 64'(((m & ((64'd1 << sh) - 1)) != 0));
			ex = 0;
		end
		mant = m >> 39;
		rem = m & ((64'd1 << 39) - 1);
		up = rem > (64'd1 << 38) || (rem == (64'd1 << 38) && mant[0]);
		u = (64'(ex > 0 ? ex - 1 : 0) << 23) + mant + 64'(up);
		if (u >= 64'h7F800000) return {sgn, 31'h7F800000};
		return {sgn, u[30:0]};
	endfunction

	function automatic logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
		bit sgn;
		int ea, eb;
		logic [23:0] ma, mb;
		sgn = a[31] ^ b[31];
		if (f_nan(a) || f_nan(b)) return fis_pkg::FP_QNAN;
		if (f_inf(a) || f_inf(b)) begin
			if (f_zero(a) || f_zero(b)) return fis_pkg::FP_QNAN;
			return {sgn, 31'h7F800000};
		end
		if (f_zero(a) || f_zero(b)) return {sgn, 31'd0};
		split(a, ea, ma);
		split(b, eb, mb);
		return pack_round(sgn, ea + eb - 126, (64'(ma) * 64'(mb)) << 15);
	endfunction

	function automatic logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
		bit sa, sb, ts;
		int ea, eb, d, ti;
		logic [23:0] ma, mb, tm;
		logic [63:0] xa, xb, r;
		sa = a[31];
		sb = b[31];
		if (f_nan(a) || f_nan(b)) return fis_pkg::FP_QNAN;
		if (f_inf(a) && f_inf(b)) return (sa == sb) ? a : fis_pkg::FP_QNAN;
		if (f_inf(a)) return a;
		if (f_inf(b)) return b;
		if (f_zero(a) && f_zero(b)) return {sa & sb, 31'd0};
		if (f_zero(a)) return b;
		if (f_zero(b)) return a;
		split(a, ea, ma);
		split(b, eb, mb);
		if (eb > ea || (eb == ea && mb > ma)) begin
			ts = sa; sa = sb; sb = ts;
			tm = ma; ma = mb; mb = tm;
			ti = ea; ea = eb; eb = ti;
		end
		xa = 64'(ma) << 39;
		xb = 64'(mb) << 39;
		d = ea - eb;
		if (d > 62) xb = 64'd1;
		else if (d > 0) xb = (xb >> d) | 64'(((xb & ((64'd1 << d) - 1)) != 0));
		if (sa == sb) begin
			r = xa + xb;
			if (r[63]) begin
				r = (r >> 1) | 64'(r[0]);
				ea++;
			end
		end else begin
			r = xa - xb;
			// exact cancellation gives +0
			if (r == 0) return 32'd0;
		end
		return pack_round(sa, ea, r);
	endfunction

	function automatic logic [31:0] predict_rsqrt(logic [31:0] x);
		logic [31:0] guess, xhalf, t, c;
		guess = TWIST - {x[31], x[31:1]};
		xhalf = fmul(x, fis_pkg::FP_HALF);
		t = fmul(fmul(xhalf, guess), guess);
		c = fadd(fis_pkg::FP_THREE_HALVES, t ^ fis_pkg::SIGN_MASK);
		return fmul(guess, c);
	endfunction

	int mismatches = 0;

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %08h expected %08h at %0t", what, got, want, $time);
		mismatches++;
	endtask

	class rsqrt_scoreboard;
		logic [31:0] pending[$];
		logic [31:0] operands[$];
		function void note_request(logic [31:0] x);
			operands.push_back(x);
			pending.push_back(predict_rsqrt(x));
		endfunction
		task check_result(logic [31:0] got);
			logic [31:0] want, x;
			if (pending.size() == 0) begin
				report("unexpected result", got, 32'hx);
				return;
			end
			want = pending.pop_front();
			x = operands.pop_front();
			if (got !== want) report($sformatf("recip_root_bits for %08h", x), got, want);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #5 clk = ~clk;

	operand_if operand();
	result_if result();

	fast_inverse_sqrt dut (
		.clk(clk),
		.arst_n(arst_n),
		.operand(operand.sink),
		.result(result.source)
	);

	rsqrt_scoreboard board = new();

	// idle/stall odds in percent, changed per phase
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_off = 0;  // long receiver hold-off, cycles
	bit stim_done = 0;

	initial begin
		operand.valid = 1'b0;
		operand.operand_bits = '0;
		result.ready = 1'b0;
	end

	// accepted traffic is observed at the rising edge on both channels
	always @(posedge clk) begin
		if (arst_n && operand.valid && operand.ready) board.note_request(operand.operand_bits);
		if (arst_n && result.valid && result.ready) board.check_result(result.recip_root_bits);
	end

	// receiver: ready changes on the falling edge only
	always @(negedge clk) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else if (hold_off > 0) begin
			result.ready <= 1'b0;
			hold_off <= hold_off - 1;
		end else begin
			result.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// one request: optional idle cycles, then hold valid until accepted
	task automatic send_request(logic [31:0] x);
		while ($urandom_range(99) < send_idle_pct) begin
			operand.valid <= 1'b0;
			@(negedge clk);
		end
		operand.valid <= 1'b1;
		operand.operand_bits <= x;
		@(posedge clk);
		while (!operand.ready) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [31:0] random_operand();
		logic [31:0] x;
		x = $urandom();
		case ($urandom_range(9))
			0: x[30:23] = 8'hFF;                       // inf / nan
			1: x[30:23] = 8'h00;                       // zero / subnormal
			2: x[30:0] = {8'h00, 23'(1 << $urandom_range(22))};
			3: x[31] = 1'b0;
			4, 5: x = {1'b0, 8'($urandom_range(100, 154)), x[22:0]};
			default: ;
		endcase
		return x;
	endfunction

	logic [31:0] directed[$] = '{
		32'h00000000, 32'h80000000, 32'h00000001, 32'h80000001, 32'h007FFFFF,
		32'h00800000, 32'h3F800000, 32'h40800000, 32'h3E800000, 32'h7F7FFFFF,
		32'hFF7FFFFF, 32'h7F800000, 32'hFF800000, 32'h7FC00000, 32'h7F800001,
		32'hFFFFFFFF, 32'hBF800000, 32'h5F3759DF, 32'h3FFFFFFF, 32'h00400000,
		32'h7E000000, 32'h01000000, 32'hAAAAAAAA, 32'h55555555
	};

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i]) send_request(directed[i]);

		// phases: free-running, slow sender, slow receiver, both with light idle and stall
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? 85 : 0;
			recv_stall_pct = (ph == 2 || ph == 3) ? 85 : 0;
			if (ph == 3) begin
				send_idle_pct = 9;
				recv_stall_pct = 9;
			end
			// receiver backs off hard while the pipe fills and input stalls
			if (ph == 0) hold_off = 60;
			for (int n = 0; n < 370; n++) send_request(random_operand());
		end
		operand.valid <= 1'b0;
		recv_stall_pct = 0;

		while (board.pending.size() != 0) @(posedge clk);
		repeat (PIPE_LATENCY + 5) @(posedge clk);
		if (mismatches == 0 && board.pending.size() == 0) begin
			$display("tb_fast_inverse_sqrt: PASS");
		end else begin
			$display("tb_fast_inverse_sqrt: FAIL");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("tb_fast_inverse_sqrt: FAIL");
		$finish;
	end

endmodule
